// ----- rtl/dtlr_pkg.sv -----
package dtlr_pkg;

  localparam int MAX_DIM      = 64;
  localparam int DEPTH_BITS_D = 24;
  localparam int FRAC         = 16;
  localparam int COORD_W      = 13;
  localparam int PIX_W        = 6;
  localparam int DIM_W        = 7;
  localparam int ADDR_W       = $clog2(MAX_DIM * MAX_DIM);
  localparam int STEP_W       = 14;
  localparam int ERR_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_CMP    = 2'd2,
    REG_WR_ON  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMP_NEVER = 3'd0,
    CMP_LT    = 3'd1,
    CMP_EQ    = 3'd2,
    CMP_LE    = 3'd3,
    CMP_GT    = 3'd4,
    CMP_NE    = 3'd5,
    CMP_GE    = 3'd6,
    CMP_ALWAYS = 3'd7
  } depth_cmp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_WALK,
    B_TEST,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    depth_cmp_t       cmp;
    logic             wr_on;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [14:0]        dx;
    logic signed [14:0]        dy;
    logic                      sx;
    logic                      sy;
    logic [STEP_W-1:0]         steps_left;
    logic [31:0]               color;
  } walk_rec_t;

  function automatic logic depth_pass(input logic [31:0] nz, input logic [31:0] oz,
                                      input depth_cmp_t fn);
    logic r;
    case (fn)
      CMP_NEVER:  r = 1'b0;
      CMP_LT:     r = nz < oz;
      CMP_EQ:     r = nz == oz;
      CMP_LE:     r = nz <= oz;
      CMP_GT:     r = nz > oz;
      CMP_NE:     r = nz != oz;
      CMP_GE:     r = nz >= oz;
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/dtlr_fifo.sv -----
module dtlr_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);
  import dtlr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ----- rtl/dtlr_front.sv -----
module dtlr_front #(
  parameter int DEPTH_BITS = dtlr_pkg::DEPTH_BITS_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [12:0]            x0_in,
  input  logic signed [12:0]            y0_in,
  input  logic signed [12:0]            x1_in,
  input  logic signed [12:0]            y1_in,
  input  logic [DEPTH_BITS-1:0]         z0_in,
  input  logic [DEPTH_BITS-1:0]         z1_in,
  input  logic [31:0]                   color_in,
  output logic                          q_push,
  input  logic                          q_full,
  output dtlr_pkg::walk_rec_t           rec_out,
  output logic [DEPTH_BITS+15:0]        accum_out,
  output logic [DEPTH_BITS+15:0]        inc_out
);
  import dtlr_pkg::*;

  localparam int ACC_W = DEPTH_BITS + FRAC;
  localparam int CNT_W = $clog2(ACC_W);

  front_state_t state, state_next;

  walk_rec_t          rec;
  logic [ACC_W-1:0]   accum;
  logic [ACC_W-1:0]   quo;
  logic [12:0]        rem;
  logic [12:0]        divisor;
  logic [CNT_W-1:0]   cnt;
  logic               neg;

  logic               accept;
  logic signed [13:0] ddx, ddy;
  logic [12:0]        adx, ady, steps;
  logic [DEPTH_BITS:0] zd;
  logic [DEPTH_BITS-1:0] mag;
  logic [13:0]        rs;
  logic               ge;

  assign accept = in_valid && in_ready;

  always_comb begin
    ddx   = {x1_in[12], x1_in} - {x0_in[12], x0_in};
    ddy   = {y1_in[12], y1_in} - {y0_in[12], y0_in};
    adx   = ddx[13] ? 13'(-ddx) : ddx[12:0];
    ady   = ddy[13] ? 13'(-ddy) : ddy[12:0];
    steps = (adx > ady) ? adx : ady;
    zd    = {1'b0, z1_in} - {1'b0, z0_in};
    mag   = zd[DEPTH_BITS] ? DEPTH_BITS'(-zd) : zd[DEPTH_BITS-1:0];
    rs    = {rem, quo[ACC_W-1]};
    ge    = rs >= {1'b0, divisor};
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) state_next = (steps == '0) ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (cnt == '0) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state == F_IDLE;
    q_push   = (state == F_PUSH) && !q_full;
  end

  assign rec_out   = rec;
  assign accum_out = accum;
  assign inc_out   = neg ? ACC_W'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec.x0         <= x0_in;
      rec.y0         <= y0_in;
      rec.dx         <= {2'b00, adx};
      rec.dy         <= 15'(-$signed({2'b00, ady}));
      rec.sx         <= x0_in < x1_in;
      rec.sy         <= y0_in < y1_in;
      rec.steps_left <= {1'b0, steps} + STEP_W'(1);
      rec.color      <= color_in;
      accum          <= {z0_in, FRAC'(0)};
      quo            <= (steps == '0) ? '0 : {mag, FRAC'(0)};
      neg            <= zd[DEPTH_BITS];
      rem            <= '0;
      divisor        <= steps;
      cnt            <= CNT_W'(ACC_W - 1);
    end else if (state == F_DIV) begin
      rem <= ge ? 13'(rs - {1'b0, divisor}) : rs[12:0];
      quo <= {quo[ACC_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/dtlr_back.sv -----
module dtlr_back #(
  parameter int DEPTH_BITS = dtlr_pkg::DEPTH_BITS_D
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dtlr_pkg::cfg_t           cfg,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  dtlr_pkg::walk_rec_t      rec_in,
  input  logic [DEPTH_BITS+15:0]   accum_in,
  input  logic [DEPTH_BITS+15:0]   inc_in,
  output logic                     clearing,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [5:0]               pixel_x,
  output logic [5:0]               pixel_y,
  output logic [31:0]              color_out,
  output logic [DEPTH_BITS-1:0]    depth_out,
  output logic                     passed,
  output logic                     depth_written,
  output logic                     on_screen,
  output logic                     last
);
  import dtlr_pkg::*;

  localparam int ACC_W = DEPTH_BITS + FRAC;
  localparam int MEM_N = MAX_DIM * MAX_DIM;

  back_state_t state, state_next;

  logic [DEPTH_BITS-1:0] mem [MEM_N];
  logic [DEPTH_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]     clr_cnt;
  logic [ADDR_W-1:0]     idx_q;

  logic signed [COORD_W-1:0] wx, wy;
  logic signed [ERR_W-1:0]   err;
  logic signed [14:0]        dx, dy;
  logic                      sx, sy;
  logic [STEP_W-1:0]         steps_left;
  logic [ACC_W-1:0]          accum, inc;
  logic [31:0]               color;

  logic                  pend_valid;
  logic [5:0]            pend_x, pend_y;
  logic [31:0]           pend_color;
  logic [DEPTH_BITS-1:0] pend_depth;
  logic                  pend_pass, pend_wr;

  logic [DIM_W-1:0]      w_eff, h_eff;
  logic                  on;
  logic [ADDR_W-1:0]     idx;
  logic [DEPTH_BITS-1:0] nz;
  logic                  ok, wr;
  logic                  out_free, can;
  logic                  rd_en, step_go, emit_pend, load_pend, finish_emit;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [DEPTH_BITS-1:0] mem_wd;
  logic signed [ERR_W:0] e2;
  logic                  c1, c2;

  always_comb begin
    w_eff = clamp_dim(cfg.width);
    h_eff = clamp_dim(cfg.height);
    on    = !wx[COORD_W-1] && !wy[COORD_W-1] &&
            (wx[COORD_W-2:0] < 12'(w_eff)) && (wy[COORD_W-2:0] < 12'(h_eff));
    idx   = ADDR_W'(wy[PIX_W-1:0] * w_eff + 13'(wx[PIX_W-1:0]));
    nz    = accum[ACC_W-1:FRAC];
    ok    = depth_pass(32'(nz), 32'(rd_data), cfg.cmp);
    wr    = ok && cfg.wr_on;
    out_free = !out_valid || out_ready;
    can   = !pend_valid || out_free;
    e2    = {err, 1'b0};
    c1    = e2 >= (ERR_W+1)'(dy);
    c2    = e2 <= (ERR_W+1)'(dx);
  end

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clr_cnt == '1) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid) state_next = B_WALK;
      end
      B_WALK: begin
        if (on) state_next = B_TEST;
        else if (steps_left == STEP_W'(1)) state_next = B_DONE;
      end
      B_TEST: begin
        if (can) state_next = (steps_left == STEP_W'(1)) ? B_DONE : B_WALK;
      end
      B_DONE: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing    = state == B_CLEAR;
    q_pop       = (state == B_IDLE) && q_valid;
    rd_en       = (state == B_WALK) && on;
    step_go     = ((state == B_WALK) && !on) || ((state == B_TEST) && can);
    load_pend   = (state == B_TEST) && can;
    emit_pend   = (state == B_TEST) && can && pend_valid;
    finish_emit = (state == B_DONE) && out_free;
    mem_we      = clearing || ((state == B_TEST) && can && wr);
    mem_wa      = clearing ? clr_cnt : idx_q;
    mem_wd      = clearing ? '1 : nz;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (load_pend) pend_valid <= 1'b1;
      else if (finish_emit) pend_valid <= 1'b0;
      if (emit_pend || finish_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wx         <= rec_in.x0;
      wy         <= rec_in.y0;
      err        <= ERR_W'(rec_in.dx) + ERR_W'(rec_in.dy);
      dx         <= rec_in.dx;
      dy         <= rec_in.dy;
      sx         <= rec_in.sx;
      sy         <= rec_in.sy;
      steps_left <= rec_in.steps_left;
      color      <= rec_in.color;
      accum      <= accum_in;
      inc        <= inc_in;
    end else if (step_go) begin
      if (c1) wx <= sx ? wx + COORD_W'(1) : wx - COORD_W'(1);
      if (c2) wy <= sy ? wy + COORD_W'(1) : wy - COORD_W'(1);
      err <= err + (c1 ? ERR_W'(dy) : ERR_W'(0)) + (c2 ? ERR_W'(dx) : ERR_W'(0));
      accum      <= accum + inc;
      steps_left <= steps_left - STEP_W'(1);
    end
    if (rd_en) idx_q <= idx;
    if (load_pend) begin
      pend_x     <= wx[PIX_W-1:0];
      pend_y     <= wy[PIX_W-1:0];
      pend_color <= ok ? color : 32'd0;
      pend_depth <= nz;
      pend_pass  <= ok;
      pend_wr    <= wr;
    end
    if (emit_pend || finish_emit) begin
      if (pend_valid) begin
        pixel_x       <= pend_x;
        pixel_y       <= pend_y;
        color_out     <= pend_color;
        depth_out     <= pend_depth;
        passed        <= pend_pass;
        depth_written <= pend_wr;
        on_screen     <= 1'b1;
      end else begin
        pixel_x       <= '0;
        pixel_y       <= '0;
        color_out     <= '0;
        depth_out     <= '0;
        passed        <= 1'b0;
        depth_written <= 1'b0;
        on_screen     <= 1'b0;
      end
      last <= finish_emit;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    state == B_CLEAR |-> !q_pop) else $error("command taken during clear");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> !pend_valid) else $error("pixel left over between lines");
  a_walk_steps: assert property (@(posedge clk) disable iff (rst)
    (state == B_WALK || state == B_TEST) |-> steps_left != '0)
    else $error("walk with no steps left");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (emit_pend || finish_emit) |-> out_free) else $error("output overwritten");
`endif

endmodule

// ----- rtl/depth_tested_line_raster_unit.sv -----
// Line rasterizer with depth test. One line command on s_* yields one beat on m_* per
// on-screen pixel (tlast on the final one), or a single marker beat with on_screen=0
// when no pixel lands on screen. The front end computes the walk setup and the depth
// slope with a bit-serial divider (skipped for single-point lines) and feeds a
// two-entry command queue, so the next command's division overlaps the current walk.
// The back end walks one step per cycle off screen; each on-screen pixel takes a
// registered depth read, then test and write-back (held while the output is stalled),
// and a done state closes the line. After reset the depth store (MAX_DIM*MAX_DIM
// entries) is swept to far, during which s_tready is low.
module depth_tested_line_raster_unit #(
  parameter int DEPTH_BITS = dtlr_pkg::DEPTH_BITS_D,
  localparam int IN_W  = ((84 + 2 * DEPTH_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((44 + DEPTH_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // start_x, start_y, end_x, end_y, start_depth, end_depth, line_color
  input  logic [IN_W-1:0]                       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // pixel_x, pixel_y, color_out, depth_out
  output logic [OUT_W-1:0]                      m_tdata,
  // passed, depth_written, on_screen
  output logic [2:0]                            m_tuser,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [dtlr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtlr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dtlr_pkg::*;

  localparam int ACC_W = DEPTH_BITS + FRAC;
  localparam int Q_W   = $bits(walk_rec_t) + 2 * ACC_W;

  cfg_t cfg;

  logic                  clearing;
  logic                  front_ready;
  logic                  q_push, q_full, q_pop, q_valid;
  walk_rec_t             rec_f, rec_b;
  logic [ACC_W-1:0]      accum_f, inc_f, accum_b, inc_b;
  logic [Q_W-1:0]        q_out;
  logic [5:0]            pixel_x, pixel_y;
  logic [31:0]           color_out;
  logic [DEPTH_BITS-1:0] depth_out;
  logic                  passed, depth_written, on_screen;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_W'(MAX_DIM);
      cfg.height <= DIM_W'(MAX_DIM);
      cfg.cmp    <= CMP_LT;
      cfg.wr_on  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  cfg.width  <= cfg_data;
        REG_HEIGHT: cfg.height <= cfg_data;
        REG_CMP:    cfg.cmp    <= depth_cmp_t'(cfg_data[2:0]);
        REG_WR_ON:  cfg.wr_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = front_ready && !clearing;

  dtlr_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && !clearing),
    .in_ready  (front_ready),
    .x0_in     (s_tdata[12:0]),
    .y0_in     (s_tdata[25:13]),
    .x1_in     (s_tdata[38:26]),
    .y1_in     (s_tdata[51:39]),
    .z0_in     (s_tdata[52 +: DEPTH_BITS]),
    .z1_in     (s_tdata[52 + DEPTH_BITS +: DEPTH_BITS]),
    .color_in  (s_tdata[52 + 2 * DEPTH_BITS +: 32]),
    .q_push    (q_push),
    .q_full    (q_full),
    .rec_out   (rec_f),
    .accum_out (accum_f),
    .inc_out   (inc_f)
  );

  dtlr_fifo #(.W(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({rec_f, accum_f, inc_f}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid)
  );

  assign {rec_b, accum_b, inc_b} = q_out;

  dtlr_back #(.DEPTH_BITS(DEPTH_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .rec_in        (rec_b),
    .accum_in      (accum_b),
    .inc_in        (inc_b),
    .clearing      (clearing),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .color_out     (color_out),
    .depth_out     (depth_out),
    .passed        (passed),
    .depth_written (depth_written),
    .on_screen     (on_screen),
    .last          (m_tlast)
  );

  assign m_tdata = OUT_W'({depth_out, color_out, pixel_y, pixel_x});
  assign m_tuser = {on_screen, depth_written, passed};

endmodule

// ----- tb/line_raster_checker.sv -----
`timescale 1ns / 1ps
module line_raster_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data,
  output int           fails,
  output int           pending,
  output int           pixels_seen,
  output int           markers_seen
);
  import dtlr_pkg::*;

  typedef struct packed {
    logic [5:0]  px;
    logic [5:0]  py;
    logic [31:0] color;
    logic [23:0] depth;
    logic        passed;
    logic        written;
    logic        on_screen;
    logic        last;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [23:0] zbuf[MAX_DIM*MAX_DIM];
  logic [6:0]  width_reg, height_reg;
  depth_cmp_t  cmp_reg;
  logic        wr_on_reg;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fails++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic z_test(input logic [23:0] nz, input logic [23:0] oz);
    case (cmp_reg)
      CMP_NEVER:  return 1'b0;
      CMP_LT:     return nz < oz;
      CMP_EQ:     return nz == oz;
      CMP_LE:     return nz <= oz;
      CMP_GT:     return nz > oz;
      CMP_NE:     return nz != oz;
      CMP_GE:     return nz >= oz;
      default:    return 1'b1;
    endcase
  endfunction

  task automatic rasterize_line(input logic [135:0] d);
    int x0, y0, x1, y1, dx, dy, sx, sy, steps, w, h, x, y, err, e2, n, idx;
    longint z0, z1, inc;
    logic [39:0] acc;
    logic [23:0] nz;
    logic ok;
    pixel_t p;
    x0 = int'($signed(d[12:0]));  y0 = int'($signed(d[25:13]));
    x1 = int'($signed(d[38:26])); y1 = int'($signed(d[51:39]));
    z0 = 64'(d[75:52]); z1 = 64'(d[99:76]);
    w = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    steps = (dx > -dy) ? dx : -dy;
    inc = (steps > 0) ? ((z1 - z0) * 65536) / steps : 0;
    acc = 40'(z0 << 16);
    x = x0; y = y0; err = dx + dy; n = 0;
    for (int s = 0; s <= steps; s++) begin
      if (x >= 0 && y >= 0 && x < w && y < h && n < MAX_DIM) begin
        idx = (y * w + x) & (MAX_DIM * MAX_DIM - 1);
        nz = acc[39:16];
        ok = z_test(nz, zbuf[idx]);
        if (ok && wr_on_reg) zbuf[idx] = nz;
        p.px = 6'(x); p.py = 6'(y);
        p.color = ok ? d[131:100] : 32'd0;
        p.depth = nz; p.passed = ok; p.written = ok && wr_on_reg;
        p.on_screen = 1'b1; p.last = 1'b0;
        pixel_q = {pixel_q, p};
        n++;
      end
      e2 = 2 * err;
      if (e2 >= dy) begin err += dy; x += sx; end
      if (e2 <= dx) begin err += dx; y += sy; end
      acc = acc + inc[39:0];
    end
    if (n == 0) begin
      p = '0;
      p.last = 1'b1;
      pixel_q = {pixel_q, p};
    end else begin
      pixel_q[$].last = 1'b1;
    end
  endtask

  initial begin
    fails = 0; pending = 0; pixels_seen = 0; markers_seen = 0;
    width_reg = 7'd64; height_reg = 7'd64; cmp_reg = CMP_LT; wr_on_reg = 1'b1;
    foreach (zbuf[i]) zbuf[i] = '1;
  end

  always @(posedge clk) begin
    pixel_t e;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH:  width_reg = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          REG_CMP:    cmp_reg = depth_cmp_t'(cfg_data[2:0]);
          REG_WR_ON:  wr_on_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) rasterize_line(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected beat", m_tdata[31:0], 0);
        end else begin
          e = pixel_q.pop_front();
          if (m_tuser[2]) pixels_seen++; else markers_seen++;
          if (m_tdata[5:0] !== e.px) report("pixel_x", 32'(m_tdata[5:0]), 32'(e.px));
          if (m_tdata[11:6] !== e.py) report("pixel_y", 32'(m_tdata[11:6]), 32'(e.py));
          if (m_tdata[43:12] !== e.color) report("color_out", m_tdata[43:12], e.color);
          if (m_tdata[67:44] !== e.depth)
            report("depth_out", 32'(m_tdata[67:44]), 32'(e.depth));
          if (m_tuser[0] !== e.passed) report("passed", 32'(m_tuser[0]), 32'(e.passed));
          if (m_tuser[1] !== e.written)
            report("depth_written", 32'(m_tuser[1]), 32'(e.written));
          if (m_tuser[2] !== e.on_screen)
            report("on_screen", 32'(m_tuser[2]), 32'(e.on_screen));
          if (m_tlast !== e.last) report("last", 32'(m_tlast), 32'(e.last));
        end
      end
    end
    pending = pixel_q.size();
  end
endmodule

// ----- tb/tb_depth_tested_line_raster_unit.sv -----
`timescale 1ns / 1ps
module tb_depth_tested_line_raster_unit;
  import dtlr_pkg::*;

  localparam int HOLD_AT = 300;
  localparam logic [6:0] WIDTHS[8]  = '{7'd64, 7'd0, 7'd127, 7'd17, 7'd64, 7'd1, 7'd40, 7'd64};
  localparam logic [6:0] HEIGHTS[8] = '{7'd64, 7'd127, 7'd0, 7'd33, 7'd1, 7'd64, 7'd50, 7'd64};
  localparam depth_cmp_t CMPS[8] = '{CMP_ALWAYS, CMP_NEVER, CMP_EQ, CMP_LE, CMP_GT, CMP_NE,
                                     CMP_GE, CMP_LT};

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [71:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [6:0]   cfg_data = '0;
  int fails, pending, pixels_seen, markers_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles = 0;
  logic hold_done = 1'b0;
  int lines_sent = 0;

  always #1 clk = ~clk;

  depth_tested_line_raster_unit DUT (.*);

  line_raster_checker checker_i (.*);

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver; one long hold once the stream is well under way
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && lines_sent >= HOLD_AT) begin
      m_tready <= 1'b0;
      hold_cycles <= 600;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                           input logic [23:0] z0, input logic [23:0] z1,
                           input logic [31:0] col);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, col, z1, z0, 13'(y1), 13'(x1), 13'(y0), 13'(x0)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    lines_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [6:0] w, input logic [6:0] h, input depth_cmp_t c,
                           input logic wr);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_CMP, 7'(c));
    cfg_write(REG_WR_ON, 7'(wr));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_depth();
    case ($urandom_range(5))
      0: return 24'h0;
      1: return 24'hFFFFFF;
      2: return 24'(32'h100 * $urandom_range(3));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_line;
    int x0, y0, x1, y1;
    if ($urandom_range(19) == 0) begin
      x0 = int'($signed(13'($urandom))); y0 = int'($signed(13'($urandom)));
      x1 = $urandom_range(0, 63);  y1 = $urandom_range(0, 63);
    end else begin
      x0 = int'($urandom_range(0, 84)) - 10; y0 = int'($urandom_range(0, 84)) - 10;
      x1 = int'($urandom_range(0, 84)) - 10; y1 = int'($urandom_range(0, 84)) - 10;
    end
    if ($urandom_range(1)) send_line(x0, y0, x1, y1, pick_depth(), pick_depth(), $urandom);
    else send_line(x1, y1, x0, y0, pick_depth(), pick_depth(), $urandom);
  endtask

  initial begin
    send_idle_pct = 27; recv_idle_pct = 86;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines under reset settings
    send_line(5, 5, 5, 5, 24'h123456, 24'h0, 32'hDEADBEEF);
    send_line(0, 0, 63, 0, 24'h0, 24'hFFFFFF, 32'hFFFFFFFF);
    send_line(63, 63, 63, 0, 24'hFFFFFF, 24'h0, 32'h0);
    send_line(0, 63, 63, 0, 24'h800000, 24'h800000, 32'h11223344);
    send_line(63, 0, 0, 63, 24'h000100, 24'h7FFFFF, 32'hA5A5A5A5);
    send_line(-4096, 5, 4095, 5, 24'h000010, 24'hFFFFF0, 32'h5A5A5A5A);
    send_line(10, -4096, 10, 4095, 24'h0, 24'h0, 32'h01020304);
    send_line(-4096, -4096, -4000, -4000, 24'h1, 24'h2, 32'hCAFEF00D);
    send_line(4095, 4095, 4095, 4095, 24'hFFFFFF, 24'hFFFFFF, 32'h1);
    send_line(64, 0, 64, 63, 24'h5, 24'h5, 32'h2);
    send_line(-1, -1, -10, -3, 24'h5, 24'h5, 32'h3);
    send_line(3, 1, 20, 9, 24'h0, 24'h0, 32'h4);
    send_line(20, 9, 3, 1, 24'h0, 24'h0, 32'h5);
    send_line(-5, 30, 70, 32, 24'hABCDEF, 24'h012345, 32'h6);
    send_line(30, 70, 31, -5, 24'h012345, 24'hABCDEF, 32'h7);
    send_line(5, 5, 5, 5, 24'h123456, 24'h0, 32'h8);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      configure(WIDTHS[ph], HEIGHTS[ph], CMPS[ph], ph[0] ^ ph[2]);
      if (ph == 3) begin
        send_idle_pct = 86; recv_idle_pct = 27;
      end else if (ph == 6) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int i = 0; i < 46; i++) begin
        random_line();
      end
      drain();
    end

    $display("lines sent: %0d, pixel beats: %0d, off-screen markers: %0d",
             lines_sent, pixels_seen, markers_seen);
    $display("covered all depth compare modes, write on/off, clamped screen sizes, stalls");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
